// ===== rtl/hat_pkg.sv =====
`timescale 1ns / 1ps

package hat_pkg;

    // Command codes carried in the cmd field.
    localparam logic [2:0] CMD_ACTIVATE   = 3'd0;
    localparam logic [2:0] CMD_INVALIDATE = 3'd1;
    localparam logic [2:0] CMD_VALIDATE   = 3'd2;
    localparam logic [2:0] CMD_ACQUIRE    = 3'd3;
    localparam logic [2:0] CMD_RELEASE    = 3'd4;

    // Status codes returned with each result.
    localparam logic [1:0] ST_SUCCESS        = 2'd0;
    localparam logic [1:0] ST_HANDLE_ERROR   = 2'd1;
    localparam logic [1:0] ST_INVALID_HANDLE = 2'd2;
    localparam logic [1:0] ST_NO_SPACE       = 2'd3;

    // Reserved identifiers and index values.
    localparam logic [31:0] FREE_ID     = 32'h0000_0000;
    localparam logic [31:0] RESERVED_ID = 32'hFFFF_FFFF;
    localparam logic [15:0] NO_INDEX    = 16'hFFFF;

    // A slot entry is the lock bit above the 32-bit identifier.
    localparam int SLOT_W = 33;

    // Configuration register indexes.
    localparam logic REG_FIRST_ID = 1'b0;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [15:0] handle_index;
        logic [31:0] handle_id;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] out_index;
        logic [31:0] out_id;
    } out_item_t;

    // Identifiers 0 and all-ones are never handed out; 1 is used instead.
    function automatic logic [31:0] legal_id(input logic [31:0] v);
        legal_id = (v == FREE_ID || v == RESERVED_ID) ? 32'd1 : v;
    endfunction

endpackage

// ===== rtl/hat_ram.sv =====
`timescale 1ns / 1ps

module hat_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/handle_table_allocator_core.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake        Payload
// s_        in         s_valid/s_ready  hat_pkg::in_item_t  (cmd, handle_index, handle_id)
// m_        out        m_valid/m_ready  hat_pkg::out_item_t (status, out_index, out_id)
// apb       in/out     psel/penable     first_id register at byte address 0
//
// Invalidate, validate, acquire, release and unknown commands pass through ST_READ,
// ST_CHECK and ST_RESP from acceptance to a result in the output register; one slot
// read and one compare. Activate scans the slot memory from slot 0 through ST_READ
// and ST_CHECK per slot examined, until the lowest free slot or the last slot when full.
// After reset a clearing pass writes every slot before s_ready rises.
// A result waits in the output register while m_ready is low; a new transaction is
// accepted meanwhile, and its result is held until the register frees up.

module handle_table_allocator_core #(
    parameter int NUM_SLOTS = 128
) (
    input  logic               aclk,
    input  logic               aresetn,
    // Command channel
    input  logic               s_valid,
    output logic               s_ready,
    input  hat_pkg::in_item_t  s_data,
    // Result channel
    output logic               m_valid,
    input  logic               m_ready,
    output hat_pkg::out_item_t m_data,
    // Configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    import hat_pkg::*;

    localparam int AW = $clog2(NUM_SLOTS);
    localparam logic [AW-1:0] LAST_SLOT = AW'(NUM_SLOTS - 1);
    localparam logic [15:0] NUM_SLOTS_W = 16'(NUM_SLOTS);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_RESP
    } state_t;

    state_t state_reg, state_next;
    logic [AW-1:0] addr_reg, addr_next;
    in_item_t cmd_reg, cmd_next;
    out_item_t res_reg, res_next;
    out_item_t m_data_reg, m_data_next;
    logic m_valid_reg, m_valid_next;
    logic [31:0] first_id_reg, first_id_next;
    logic [31:0] ctr_reg, ctr_next;

    logic ram_we;
    logic [SLOT_W-1:0] ram_wdata;
    logic [SLOT_W-1:0] ram_rdata;
    logic cfg_wr;

    logic [31:0] slot_id;
    logic slot_lock;
    logic [31:0] new_id;
    logic handle_ok;

    hat_ram #(
        .WIDTH(SLOT_W),
        .DEPTH(NUM_SLOTS)
    ) u_slots (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (addr_reg),
        .wdata (ram_wdata),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    // Configuration port: writes complete in the access cycle.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_FIRST_ID);
    assign prdata = (paddr[2] == REG_FIRST_ID) ? first_id_reg : 32'd0;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Shared compare unit on the slot just read.
    assign slot_id   = ram_rdata[31:0];
    assign slot_lock = ram_rdata[32];
    assign new_id    = legal_id(ctr_reg);
    assign handle_ok = (cmd_reg.handle_index < NUM_SLOTS_W)
                       && (cmd_reg.handle_id != FREE_ID)
                       && (slot_id == cmd_reg.handle_id);

    // Sequencer next-state logic.
    always_comb begin
        state_next    = state_reg;
        addr_next     = addr_reg;
        cmd_next      = cmd_reg;
        res_next      = res_reg;
        m_data_next   = m_data_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        first_id_next = first_id_reg;
        ctr_next      = ctr_reg;
        ram_we        = 1'b0;
        ram_wdata     = {1'b0, FREE_ID};

        if (cfg_wr) begin
            first_id_next = pwdata;
            ctr_next      = pwdata;
        end

        unique case (state_reg)
            ST_CLEAR: begin
                ram_we = 1'b1;
                if (addr_reg == LAST_SLOT) begin
                    addr_next  = '0;
                    state_next = ST_IDLE;
                end else begin
                    addr_next = addr_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    cmd_next   = s_data;
                    addr_next  = (s_data.cmd == CMD_ACTIVATE) ? '0 : s_data.handle_index[AW-1:0];
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                res_next.status    = ST_HANDLE_ERROR;
                res_next.out_index = cmd_reg.handle_index;
                res_next.out_id    = FREE_ID;
                state_next         = ST_RESP;
                case (cmd_reg.cmd)
                    CMD_ACTIVATE: begin
                        if (slot_id == FREE_ID) begin
                            ram_we             = 1'b1;
                            ram_wdata          = {1'b0, new_id};
                            ctr_next           = legal_id(new_id + 32'd1);
                            res_next.status    = ST_SUCCESS;
                            res_next.out_index = 16'(addr_reg);
                            res_next.out_id    = new_id;
                        end else if (addr_reg == LAST_SLOT) begin
                            res_next.status    = ST_NO_SPACE;
                            res_next.out_index = 16'd0;
                        end else begin
                            addr_next  = addr_reg + 1'b1;
                            state_next = ST_READ;
                        end
                    end
                    CMD_INVALIDATE: begin
                        if (handle_ok && !slot_lock) begin
                            ram_we             = 1'b1;
                            ram_wdata          = {1'b0, FREE_ID};
                            res_next.status    = ST_SUCCESS;
                            res_next.out_index = NO_INDEX;
                        end
                    end
                    CMD_VALIDATE: begin
                        res_next.status = handle_ok ? ST_SUCCESS : ST_INVALID_HANDLE;
                    end
                    CMD_ACQUIRE: begin
                        if (!handle_ok) begin
                            res_next.status = ST_INVALID_HANDLE;
                        end else if (!slot_lock) begin
                            ram_we          = 1'b1;
                            ram_wdata       = {1'b1, slot_id};
                            res_next.status = ST_SUCCESS;
                        end
                    end
                    CMD_RELEASE: begin
                        if (!handle_ok) begin
                            res_next.status = ST_INVALID_HANDLE;
                        end else begin
                            ram_we          = 1'b1;
                            ram_wdata       = {1'b0, slot_id};
                            res_next.status = ST_SUCCESS;
                        end
                    end
                    default: begin
                        res_next.status = ST_HANDLE_ERROR;
                    end
                endcase
            end
            ST_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_data_next  = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            addr_reg     <= '0;
            m_valid_reg  <= 1'b0;
            first_id_reg <= 32'd1;
            ctr_reg      <= 32'd1;
        end else begin
            state_reg    <= state_next;
            addr_reg     <= addr_next;
            m_valid_reg  <= m_valid_next;
            first_id_reg <= first_id_next;
            ctr_reg      <= ctr_next;
        end
        cmd_reg    <= cmd_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    // The slot memory is only written by the clearing pass or a command decision.
    a_write_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == ST_CLEAR || state_reg == ST_CHECK))
        else $error("slot memory written outside clear or check phase");

    // An activate never stamps a slot with a reserved identifier.
    a_legal_stamp: assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_we && state_reg == ST_CHECK && cmd_reg.cmd == CMD_ACTIVATE)
        |-> (ram_wdata[31:0] != FREE_ID && ram_wdata[31:0] != RESERVED_ID))
        else $error("activate stamped a reserved identifier");

    // A non-zero identifier is only reported with success.
    a_id_success: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.out_id != FREE_ID) |-> (m_data_reg.status == ST_SUCCESS))
        else $error("identifier reported on a failed transaction");

    // The clearing pass runs to the last slot before commands are taken.
    a_clear_complete: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR && addr_reg != LAST_SLOT) |=> (state_reg == ST_CLEAR))
        else $error("clearing pass left early");

    // A held result is not overwritten before it is taken.
    a_result_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> (m_valid_reg && $stable(m_data_reg)))
        else $error("pending result lost");

endmodule

// ===== tb/sv/handle_table_allocator_core_tb.sv =====
`timescale 1ns / 1ps

module handle_table_allocator_core_tb;

    import hat_pkg::*;

    localparam int SLOTS       = 128;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 200;
    // An activate on a full table is the slowest command, so this covers any work in flight.
    localparam int SETTLE      = 2 * SLOTS + 8;
    localparam logic [2:0] ADDR_FIRST_ID = 3'(REG_FIRST_ID) << 2;

    // Command codes that the block does not define.
    localparam logic [2:0] CMD_SPARE_A = 3'd5;
    localparam logic [2:0] CMD_SPARE_B = 3'd6;
    localparam logic [2:0] CMD_SPARE_C = 3'd7;

    // One line of the directed script: a register write or a command.
    typedef struct packed {
        bit          is_cfg;
        logic [31:0] cfg_value;
        in_item_t    item;
        bit          typed;
        out_item_t   want;
    } script_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_item_t    s_data;
    logic        m_valid;
    logic        m_ready;
    out_item_t   m_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Shadow copy of the slot table, the ID counter and the register.
    logic [31:0] slot_id [SLOTS];
    logic        slot_lock [SLOTS];
    logic [31:0] next_id;
    logic [31:0] first_id_reg;

    out_item_t   awaited_replies [$];
    script_row_t script [$];

    bit idle_on;
    int sink_stall;
    int mismatches;
    int n_items;
    int n_full;
    int n_checked;
    int n_configs;

    handle_table_allocator_core #(
        .NUM_SLOTS(SLOTS)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // IDs 0 and all-ones are never handed out; 1 takes their place.
    function automatic logic [31:0] usable_id(input logic [31:0] v);
        return (v == FREE_ID || v == RESERVED_ID) ? 32'd1 : v;
    endfunction

    // Applies one command to the shadow table and returns the answer it should give.
    function automatic out_item_t table_step(input in_item_t c);
        out_item_t r;
        logic      ok;
        logic      claimed;
        int        k;
        r.status    = ST_HANDLE_ERROR;
        r.out_index = c.handle_index;
        r.out_id    = FREE_ID;
        ok          = 1'b0;
        claimed     = 1'b0;
        if (c.handle_index < SLOTS && c.handle_id != FREE_ID)
            ok = (slot_id[c.handle_index] == c.handle_id);
        case (c.cmd)
            CMD_ACTIVATE: begin
                r.status    = ST_NO_SPACE;
                r.out_index = '0;
                for (k = 0; k < SLOTS; k++) begin
                    if (!claimed && slot_id[k] == FREE_ID) begin
                        claimed      = 1'b1;
                        r.out_id     = usable_id(next_id);
                        slot_id[k]   = r.out_id;
                        slot_lock[k] = 1'b0;
                        next_id      = usable_id(r.out_id + 32'd1);
                        r.out_index  = 16'(k);
                        r.status     = ST_SUCCESS;
                    end
                end
                if (!claimed)
                    n_full++;
            end
            CMD_INVALIDATE: begin
                if (ok && !slot_lock[c.handle_index]) begin
                    slot_id[c.handle_index] = FREE_ID;
                    r.out_index = NO_INDEX;
                    r.status    = ST_SUCCESS;
                end
            end
            CMD_VALIDATE: begin
                r.status = ok ? ST_SUCCESS : ST_INVALID_HANDLE;
            end
            CMD_ACQUIRE: begin
                if (!ok) begin
                    r.status = ST_INVALID_HANDLE;
                end else if (slot_lock[c.handle_index]) begin
                    r.status = ST_HANDLE_ERROR;
                end else begin
                    slot_lock[c.handle_index] = 1'b1;
                    r.status = ST_SUCCESS;
                end
            end
            CMD_RELEASE: begin
                if (!ok) begin
                    r.status = ST_INVALID_HANDLE;
                end else begin
                    slot_lock[c.handle_index] = 1'b0;
                    r.status = ST_SUCCESS;
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    // Random command, mostly aimed at live handles so that the lock and free paths are reached.
    function automatic in_item_t random_cmd(input int act_pct);
        in_item_t    c;
        int unsigned r;
        int unsigned start;
        int unsigned slot;
        int          k;
        logic        found;
        c.cmd          = CMD_ACTIVATE;
        c.handle_index = 16'($urandom);
        c.handle_id    = $urandom;
        if ($urandom_range(0, 99) < act_pct)
            return c;
        if ($urandom_range(0, 99) < 4) begin
            c.cmd = 3'($urandom_range(CMD_SPARE_A, CMD_SPARE_C));
        end else begin
            case ($urandom_range(0, 3))
                0: c.cmd = CMD_INVALIDATE;
                1: c.cmd = CMD_VALIDATE;
                2: c.cmd = CMD_ACQUIRE;
                default: c.cmd = CMD_RELEASE;
            endcase
        end
        // Find an occupied slot, searching from a random point.
        found = 1'b0;
        slot  = 0;
        start = $urandom_range(0, SLOTS - 1);
        for (k = 0; k < SLOTS; k++) begin
            if (!found && slot_id[(start + k) % SLOTS] != FREE_ID) begin
                found = 1'b1;
                slot  = (start + k) % SLOTS;
            end
        end
        r = $urandom_range(0, 99);
        if (found && r < 75) begin
            c.handle_index = 16'(slot);
            c.handle_id    = slot_id[slot];
        end else if (found && r < 87) begin
            c.handle_index = 16'(slot);
            c.handle_id    = slot_id[slot] ^ (32'd1 << $urandom_range(0, 31));
        end else if (found && r < 92) begin
            // A live ID with an index beyond the table that aliases onto its slot.
            c.handle_index = 16'(slot + SLOTS * $urandom_range(1, 65535 / SLOTS));
            c.handle_id    = slot_id[slot];
        end else if (r < 96) begin
            c.handle_index = 16'($urandom_range(SLOTS, 65535));
        end else begin
            c.handle_index = 16'($urandom_range(0, SLOTS - 1));
            if ($urandom_range(0, 1) == 0)
                c.handle_id = FREE_ID;
        end
        return c;
    endfunction

    function automatic void cmd_row(input logic [2:0] cmd, input logic [15:0] idx,
                                    input logic [31:0] id);
        script_row_t row;
        row      = '0;
        row.item = '{cmd: cmd, handle_index: idx, handle_id: id};
        script.push_back(row);
    endfunction

    function automatic void known_row(input logic [2:0] cmd, input logic [15:0] idx,
                                      input logic [31:0] id, input logic [1:0] st,
                                      input logic [15:0] oidx, input logic [31:0] oid);
        script_row_t row;
        row       = '0;
        row.item  = '{cmd: cmd, handle_index: idx, handle_id: id};
        row.typed = 1'b1;
        row.want  = '{status: st, out_index: oidx, out_id: oid};
        script.push_back(row);
    endfunction

    function automatic void cfg_row(input logic [31:0] value);
        script_row_t row;
        row           = '0;
        row.is_cfg    = 1'b1;
        row.cfg_value = value;
        script.push_back(row);
    endfunction

    // Sends one command, with an optional gap first, and records its answer on acceptance.
    task automatic issue_cmd(input in_item_t c, input bit typed, input out_item_t want);
        out_item_t got;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= c;
        do @(posedge aclk); while (!s_ready);
        got = table_step(c);
        awaited_replies.push_back(typed ? want : got);
        n_items++;
    endtask

    // Stops sending and waits until every answer has come back and the block is quiet.
    task automatic drain;
        s_valid <= 1'b0;
        while (awaited_replies.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // Writes first_id over the register port, then reads it back.
    task automatic write_first_id(input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_FIRST_ID;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        first_id_reg = value;
        next_id      = value;
        n_configs++;
        // Read-back transaction on the same register.
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== first_id_reg) begin
            $display("%0t: first_id read-back mismatch, expected %h, actual %h",
                     $time, first_id_reg, prdata);
            mismatches++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Result side: random back-pressure and the comparison against the oldest expectation.
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (awaited_replies.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, m_data);
                mismatches++;
            end else begin
                want = awaited_replies.pop_front();
                n_checked++;
                if (m_data.status !== want.status) begin
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, want.status, m_data.status);
                    mismatches++;
                end
                if (m_data.out_index !== want.out_index) begin
                    $display("%0t: out_index mismatch, expected %h, actual %h",
                             $time, want.out_index, m_data.out_index);
                    mismatches++;
                end
                if (m_data.out_id !== want.out_id) begin
                    $display("%0t: out_id mismatch, expected %h, actual %h",
                             $time, want.out_id, m_data.out_id);
                    mismatches++;
                end
            end
        end
        if (sink_stall != 0) begin
            sink_stall <= sink_stall - 1;
            m_ready    <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            sink_stall <= $urandom_range(0, 4);
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Stimulus: reset, the directed script, then random phases under several first_id values.
    initial begin
        int          phase;
        int          n;
        int          k;
        int          act_mix [PHASES];
        logic [31:0] fid;
        script_row_t row;
        act_mix    = '{55, 90, 95, 30, 60, 95, 20, 50};
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_data     = '0;
        m_ready    = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        idle_on    = 1'b1;
        sink_stall = 0;
        mismatches = 0;
        n_items    = 0;
        n_full     = 0;
        n_checked  = 0;
        n_configs  = 0;
        for (k = 0; k < SLOTS; k++) begin
            slot_id[k]   = FREE_ID;
            slot_lock[k] = 1'b0;
        end
        first_id_reg = 32'd1;
        next_id      = first_id_reg;

        // Directed script, starting from the reset value of first_id.
        known_row(CMD_VALIDATE, 16'd0, FREE_ID, ST_INVALID_HANDLE, 16'd0, FREE_ID);
        known_row(CMD_ACTIVATE, 16'hFFFF, RESERVED_ID, ST_SUCCESS, 16'd0, 32'd1);
        known_row(CMD_ACTIVATE, 16'd0, FREE_ID, ST_SUCCESS, 16'd1, 32'd2);
        cmd_row(CMD_VALIDATE, 16'd0, 32'd1);
        known_row(CMD_VALIDATE, 16'd0, RESERVED_ID, ST_INVALID_HANDLE, 16'd0, FREE_ID);
        known_row(CMD_VALIDATE, 16'hFFFF, 32'd1, ST_INVALID_HANDLE, 16'hFFFF, FREE_ID);
        known_row(CMD_VALIDATE, 16'(SLOTS), 32'd1, ST_INVALID_HANDLE, 16'(SLOTS), FREE_ID);
        cmd_row(CMD_ACQUIRE, 16'd0, 32'd1);
        known_row(CMD_ACQUIRE, 16'd0, 32'd1, ST_HANDLE_ERROR, 16'd0, FREE_ID);
        known_row(CMD_INVALIDATE, 16'd0, 32'd1, ST_HANDLE_ERROR, 16'd0, FREE_ID);
        cmd_row(CMD_RELEASE, 16'd0, 32'd1);
        cmd_row(CMD_RELEASE, 16'd0, 32'd1);
        known_row(CMD_RELEASE, 16'd5, 32'd3, ST_INVALID_HANDLE, 16'd5, FREE_ID);
        known_row(CMD_ACQUIRE, 16'd200, 32'd2, ST_INVALID_HANDLE, 16'd200, FREE_ID);
        known_row(CMD_INVALIDATE, 16'd0, 32'd1, ST_SUCCESS, NO_INDEX, FREE_ID);
        known_row(CMD_INVALIDATE, 16'd0, 32'd1, ST_HANDLE_ERROR, 16'd0, FREE_ID);
        cmd_row(CMD_ACTIVATE, 16'd0, FREE_ID);
        known_row(CMD_SPARE_A, 16'h1234, 32'h55AA_55AA, ST_HANDLE_ERROR, 16'h1234, FREE_ID);
        known_row(CMD_SPARE_B, 16'd1, 32'd2, ST_HANDLE_ERROR, 16'd1, FREE_ID);
        known_row(CMD_SPARE_C, 16'hFFFF, RESERVED_ID, ST_HANDLE_ERROR, 16'hFFFF, FREE_ID);
        // Counter wrap from the top of the legal range, then the two illegal start values.
        cfg_row(32'hFFFF_FFFE);
        known_row(CMD_ACTIVATE, 16'd0, FREE_ID, ST_SUCCESS, 16'd2, 32'hFFFF_FFFE);
        known_row(CMD_ACTIVATE, 16'd0, FREE_ID, ST_SUCCESS, 16'd3, 32'd1);
        cfg_row(FREE_ID);
        known_row(CMD_ACTIVATE, 16'd0, FREE_ID, ST_SUCCESS, 16'd4, 32'd1);
        cfg_row(RESERVED_ID);
        known_row(CMD_ACTIVATE, 16'd0, FREE_ID, ST_SUCCESS, 16'd5, 32'd1);

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (script[i]) begin
            row = script[i];
            if (row.is_cfg) begin
                drain();
                write_first_id(row.cfg_value);
            end else begin
                issue_cmd(row.item, row.typed, row.want);
            end
        end

        // Random phases; each starts with the block drained and a new first_id.
        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: fid = 32'd1;
                1: fid = 32'hFFFF_FFF0;
                2: fid = FREE_ID;
                3: fid = RESERVED_ID;
                4: fid = $urandom;
                5: fid = 32'h8000_0000;
                6: fid = 32'hFFFF_FFFE;
                default: fid = 32'd2;
            endcase
            drain();
            idle_on = (phase < PHASES - 2) && (phase != 2);
            write_first_id(fid);
            for (n = 0; n < PHASE_ITEMS; n++)
                issue_cmd(random_cmd(act_mix[phase]), 1'b0, '0);
        end
        drain();

        $display("Covered %0d commands under %0d first_id writes, %0d activates on a full table.",
                 n_items, n_configs, n_full);
        $display("%0d results compared, %0d mismatches.", n_checked, mismatches);
        if (mismatches == 0) begin
            $display("handle_table_allocator_core_tb OK");
        end else begin
            $display("handle_table_allocator_core_tb NOT OK");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #5_000_000;
        $display("Timeout with %0d results still awaited.", awaited_replies.size());
        $display("handle_table_allocator_core_tb NOT OK");
        $finish;
    end

endmodule
